### rtl/rsk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rsk_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int HEAD_W    = 64;
  localparam int TAIL_W    = 8;
  localparam int KEY_W     = HEAD_W + TAIL_W;
  localparam int COST_W    = 32;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [KEY_W-1:0]         key_t;
  typedef logic signed [COST_W-1:0] cost_t;

  // source of the first read address of the key/cost store
  typedef enum logic {
    A_SEL_I,
    A_SEL_PERM
  } a_sel_t;

  typedef struct packed {
    logic   in_ready;
    a_sel_t a_sel;
    idx_t   idx_i;
    idx_t   idx_j;
    logic   scan_issue;
    logic   rank_clr;
    logic   perm_wr;
    idx_t   perm_rd_addr;
    logic   out_load;
    logic   out_last;
    logic   set_clear;
  } rsk_cmd_t;

  typedef struct packed {
    logic in_fire;
    logic in_last;
    cnt_t count;
    logic out_free;
  } rsk_sts_t;

endpackage

`default_nettype wire

### rtl/rsk_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rsk_in_if;
  logic                            valid;
  logic                            ready;
  logic [rsk_pkg::HEAD_W-1:0]      key_head;
  logic [rsk_pkg::TAIL_W-1:0]      key_tail;
  logic signed [rsk_pkg::COST_W-1:0] cost;
  logic                            last_record;

  modport source (output valid, key_head, key_tail, cost, last_record, input ready);
  modport sink   (input valid, key_head, key_tail, cost, last_record, output ready);
endinterface

interface rsk_out_if;
  logic                            valid;
  logic                            ready;
  logic [rsk_pkg::HEAD_W-1:0]      sorted_key_head;
  logic [rsk_pkg::TAIL_W-1:0]      sorted_key_tail;
  logic signed [rsk_pkg::COST_W-1:0] sorted_cost;
  logic signed [rsk_pkg::COST_W-1:0] min_cost;
  logic signed [rsk_pkg::COST_W-1:0] max_cost;
  logic                            overflow;
  logic                            last_out;

  modport source (output valid, sorted_key_head, sorted_key_tail, sorted_cost, min_cost,
                  max_cost, overflow, last_out, input ready);
  modport sink   (input valid, sorted_key_head, sorted_key_tail, sorted_cost, min_cost,
                  max_cost, overflow, last_out, output ready);
endinterface

`default_nettype wire

### rtl/rsk_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module rsk_dp (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire rsk_pkg::rsk_cmd_t                cmd,
  output rsk_pkg::rsk_sts_t                     sts,
  input  wire logic                             in_valid,
  input  wire logic [rsk_pkg::HEAD_W-1:0]       in_key_head,
  input  wire logic [rsk_pkg::TAIL_W-1:0]       in_key_tail,
  input  wire rsk_pkg::cost_t                   in_cost,
  input  wire logic                             in_last_record,
  rsk_out_if.source                             out_ch
);

  rsk_pkg::key_t  key_mem  [rsk_pkg::MAX_ITEMS];
  rsk_pkg::cost_t cost_mem [rsk_pkg::MAX_ITEMS];
  rsk_pkg::idx_t  perm_mem [rsk_pkg::MAX_ITEMS];

  rsk_pkg::cnt_t  count_r, count_nxt;
  logic           dropped_r, dropped_nxt;
  rsk_pkg::cost_t min_r, min_nxt;
  rsk_pkg::cost_t max_r, max_nxt;
  logic           scan_v_r;
  rsk_pkg::idx_t  rank_r, rank_nxt;
  rsk_pkg::idx_t  j_d_r;
  rsk_pkg::key_t  key_a_r, key_b_r;
  rsk_pkg::cost_t cost_a_r;
  rsk_pkg::idx_t  perm_rd_r;
  rsk_pkg::idx_t  addr_a;
  logic           out_valid_r;
  rsk_pkg::key_t  out_key_r;
  rsk_pkg::cost_t out_cost_r, out_min_r, out_max_r;
  logic           out_ovf_r, out_last_r;
  logic           in_fire, store_ok, first_rec, key_less;

  assign in_fire   = in_valid && cmd.in_ready;
  assign store_ok  = count_r < rsk_pkg::cnt_t'(rsk_pkg::MAX_ITEMS);
  assign first_rec = (count_r == '0) && !dropped_r;
  assign addr_a    = (cmd.a_sel == rsk_pkg::A_SEL_PERM) ? perm_rd_r : cmd.idx_i;

  // equal keys fall back to arrival index so the order stays stable
  assign key_less = (key_b_r < key_a_r) || ((key_b_r == key_a_r) && (j_d_r < cmd.idx_i));

  assign sts.in_fire  = in_fire;
  assign sts.in_last  = in_last_record;
  assign sts.count    = count_r;
  assign sts.out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    min_nxt     = min_r;
    max_nxt     = max_r;
    rank_nxt    = rank_r;
    if (in_fire) begin
      if (first_rec) begin
        min_nxt = in_cost;
        max_nxt = in_cost;
      end else begin
        if (in_cost > max_r) max_nxt = in_cost;
        if (in_cost < min_r) min_nxt = in_cost;
      end
      if (store_ok) begin
        count_nxt = count_r + rsk_pkg::cnt_t'(1);
      end else begin
        dropped_nxt = 1'b1;
      end
    end
    if (cmd.set_clear) begin
      count_nxt   = '0;
      dropped_nxt = 1'b0;
      min_nxt     = '0;
      max_nxt     = '0;
    end
    if (cmd.rank_clr) begin
      rank_nxt = '0;
    end else if (scan_v_r && key_less) begin
      rank_nxt = rank_r + rsk_pkg::idx_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      dropped_r   <= 1'b0;
      min_r       <= '0;
      max_r       <= '0;
      scan_v_r    <= 1'b0;
      rank_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
      min_r     <= min_nxt;
      max_r     <= max_nxt;
      scan_v_r  <= cmd.scan_issue;
      rank_r    <= rank_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    j_d_r <= cmd.idx_j;
    if (cmd.out_load) begin
      out_key_r  <= key_a_r;
      out_cost_r <= cost_a_r;
      out_min_r  <= min_r;
      out_max_r  <= max_r;
      out_ovf_r  <= dropped_r;
      out_last_r <= cmd.out_last;
    end
  end

  // record store and permutation store
  always_ff @(posedge clk) begin
    if (in_fire && store_ok) begin
      key_mem[count_r[rsk_pkg::IDX_W-1:0]]  <= {in_key_head, in_key_tail};
      cost_mem[count_r[rsk_pkg::IDX_W-1:0]] <= in_cost;
    end
    if (cmd.perm_wr) begin
      perm_mem[rank_r] <= cmd.idx_i;
    end
    key_a_r   <= key_mem[addr_a];
    cost_a_r  <= cost_mem[addr_a];
    key_b_r   <= key_mem[cmd.idx_j];
    perm_rd_r <= perm_mem[cmd.perm_rd_addr];
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.sorted_key_head = out_key_r[rsk_pkg::KEY_W-1:rsk_pkg::TAIL_W];
  assign out_ch.sorted_key_tail = out_key_r[rsk_pkg::TAIL_W-1:0];
  assign out_ch.sorted_cost     = out_cost_r;
  assign out_ch.min_cost        = out_min_r;
  assign out_ch.max_cost        = out_max_r;
  assign out_ch.overflow        = out_ovf_r;
  assign out_ch.last_out        = out_last_r;

endmodule

`default_nettype wire

### rtl/rsk_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rsk_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rsk_pkg::rsk_sts_t sts,
  output rsk_pkg::rsk_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_LOAD,
    S_RD_I,
    S_SCAN,
    S_SCAN_END,
    S_WR_PERM,
    S_DR_PERM,
    S_DR_MEM,
    S_DR_LOAD
  } state_t;

  state_t        state_r, state_nxt;
  rsk_pkg::idx_t i_r, i_nxt;
  rsk_pkg::idx_t j_r, j_nxt;
  rsk_pkg::idx_t p_r, p_nxt;
  logic          last_i, last_j, last_p;

  assign last_i = (rsk_pkg::cnt_t'(i_r) + rsk_pkg::cnt_t'(1)) == sts.count;
  assign last_j = (rsk_pkg::cnt_t'(j_r) + rsk_pkg::cnt_t'(1)) == sts.count;
  assign last_p = (rsk_pkg::cnt_t'(p_r) + rsk_pkg::cnt_t'(1)) == sts.count;

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    p_nxt     = p_r;

    cmd              = '0;
    cmd.a_sel        = rsk_pkg::A_SEL_I;
    cmd.idx_i        = i_r;
    cmd.idx_j        = j_r;
    cmd.perm_rd_addr = p_r;

    case (state_r)
      S_LOAD: begin
        cmd.in_ready = 1'b1;
        if (sts.in_fire && sts.in_last) begin
          i_nxt     = '0;
          state_nxt = S_RD_I;
        end
      end
      S_RD_I: begin
        cmd.rank_clr = 1'b1;
        j_nxt        = '0;
        state_nxt    = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (last_j) begin
          state_nxt = S_SCAN_END;
        end else begin
          j_nxt = j_r + rsk_pkg::idx_t'(1);
        end
      end
      S_SCAN_END: begin
        // last compare lands in the rank counter
        state_nxt = S_WR_PERM;
      end
      S_WR_PERM: begin
        cmd.perm_wr = 1'b1;
        if (last_i) begin
          p_nxt     = '0;
          state_nxt = S_DR_PERM;
        end else begin
          i_nxt     = i_r + rsk_pkg::idx_t'(1);
          state_nxt = S_RD_I;
        end
      end
      S_DR_PERM: begin
        state_nxt = S_DR_MEM;
      end
      S_DR_MEM: begin
        cmd.a_sel = rsk_pkg::A_SEL_PERM;
        state_nxt = S_DR_LOAD;
      end
      S_DR_LOAD: begin
        cmd.a_sel = rsk_pkg::A_SEL_PERM;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = last_p;
          if (last_p) begin
            cmd.set_clear = 1'b1;
            state_nxt     = S_LOAD;
          end else begin
            p_nxt     = p_r + rsk_pkg::idx_t'(1);
            state_nxt = S_DR_PERM;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      i_r     <= '0;
      j_r     <= '0;
      p_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      p_r     <= p_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/rank_sort_keys_with_payload.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake      payload
// in_ch     in   valid/ready    key_head[64] key_tail[8] cost[32] last_record
// out_ch    out  valid/ready    sorted_key_head[64] sorted_key_tail[8] sorted_cost[32]
//                               min_cost[32] max_cost[32] overflow last_out
//
// records load at one item per cycle until the item flagged last_record.
// ranking then makes one pass over the stored set per stored record, one compare per cycle
// on the second read port of the key store. results then leave in three steps per item
// (permutation read, store read, output load); out_ready low holds the drain. in_ready
// is low from the last record until the final result is loaded. reset is synchronous,
// active low.

module rank_sort_keys_with_payload (
  input  wire logic clk,
  input  wire logic rst_n,
  rsk_in_if.sink    in_ch,
  rsk_out_if.source out_ch
);

  rsk_pkg::rsk_cmd_t cmd;
  rsk_pkg::rsk_sts_t sts;

  assign in_ch.ready = cmd.in_ready;

  rsk_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  rsk_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_valid       (in_ch.valid),
    .in_key_head    (in_ch.key_head),
    .in_key_tail    (in_ch.key_tail),
    .in_cost        (in_ch.cost),
    .in_last_record (in_ch.last_record),
    .out_ch         (out_ch)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sts.count <= rsk_pkg::cnt_t'(rsk_pkg::MAX_ITEMS))
    else $error("record count above capacity");

  a_last_stops_load: assert property (@(posedge clk) disable iff (!rst_n)
    (sts.in_fire && sts.in_last) |=> !in_ch.ready)
    else $error("input still open after last record");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("output register overwritten while held");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.set_clear |=> (sts.count == '0))
    else $error("record count not cleared after drain");

endmodule

`default_nettype wire
